// ===== hdl/cut_cell_flux_divergence_unit_assert.svh =====
// Assertion macros for the checker of the cut-cell flux divergence unit.
// Needs nothing else; include by bare file name inside a module.
`ifndef CUT_CELL_FLUX_DIVERGENCE_UNIT_ASSERT_SVH
`define CUT_CELL_FLUX_DIVERGENCE_UNIT_ASSERT_SVH

// Checked on every rising edge while reset is released.
`define CCFD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define CCFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ccfd_pkg.sv =====
// Shared widths, codes, types and helpers of the cut-cell flux divergence unit.
// No dependencies; every other module imports it.
package ccfd_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int NAXES      = 3;
	localparam int FLUX_W     = 32;
	localparam int AREA_W     = 16;
	localparam int PAIR_W     = 2 * AREA_W;
	localparam int VOL_W      = AREA_W;
	localparam int CLASS_W    = 2;
	localparam int INV_W      = 32;
	localparam int RATE_W     = 32;
	localparam int AFRAC_BITS = 15;
	localparam int CFG_IDX_W  = 2;

	// Item layout on the slave-side tdata bus.
	localparam int AREA_LSB  = 2 * NAXES * FLUX_W;
	localparam int VOL_LSB   = AREA_LSB + NAXES * PAIR_W;
	localparam int S_TDATA_W = ((VOL_LSB + VOL_W + 7) / 8) * 8;

	// Datapath widths.
	localparam int WPROD_W    = FLUX_W + AREA_W + 1;
	localparam int D_W        = FLUX_W + 2;
	localparam int INV_HI_W   = INV_W - FRAC_BITS;
	localparam int PLO_W      = D_W + FRAC_BITS + 1;
	localparam int PHI_W      = D_W + INV_HI_W + 1;
	localparam int TERM_W     = PHI_W;
	localparam int SUM_W      = TERM_W + 2;
	localparam int MAG_W      = RATE_W + 1;
	localparam int NUM_W      = MAG_W + AFRAC_BITS;
	localparam int Q_W        = RATE_W;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = Q_W / DIV_STEPS;

	localparam logic [AREA_W-1:0] ONE_Q15   = AREA_W'(1) << AFRAC_BITS;
	localparam logic [INV_W-1:0]  INV_RESET = INV_W'(1) << FRAC_BITS;
	localparam logic [MAG_W-1:0]  MAG_CLIP  = MAG_W'(1) << RATE_W;
	localparam logic [RATE_W-1:0] RATE_MAX  = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic [RATE_W-1:0] RATE_MIN  = {1'b1, {(RATE_W-1){1'b0}}};

	typedef enum logic [CLASS_W-1:0] {
		CLS_COVERED = 2'd0,
		CLS_REGULAR = 2'd1,
		CLS_CUT     = 2'd2
	} cell_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_X = 2'd0,
		REG_INV_Y = 2'd1,
		REG_INV_Z = 2'd2
	} cfg_reg_t;

	typedef logic [NAXES-1:0][INV_W-1:0] inv_set_t;

	// Weighted flux sum and the divisor that goes with it.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [VOL_W-1:0]        vol;
	} acc_t;

	function automatic logic [AREA_W-1:0] clamp_frac(input logic [AREA_W-1:0] a);
		return (a > ONE_Q15) ? ONE_Q15 : a;
	endfunction

endpackage

// ===== hdl/ccfd_scale.sv =====
// Front pipeline: area weighting, face differences, spacing scale and axis sum.
// Depends on ccfd_pkg. Five register stages, all advancing on en.
module ccfd_scale import ccfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [S_TDATA_W-1:0] in_data,
	input  logic [CLASS_W-1:0]   in_class,
	input  inv_set_t             inv,
	output logic                 out_valid,
	output acc_t                 out_acc
);

	logic [VOL_W-1:0]          vol_raw;
	logic [VOL_W-1:0]          vol_sel;
	logic signed [FLUX_W-1:0]  f_lo [NAXES];
	logic signed [FLUX_W-1:0]  f_hi [NAXES];
	logic [PAIR_W-1:0]         pair [NAXES];
	logic [AREA_W-1:0]         wt_lo [NAXES];
	logic [AREA_W-1:0]         wt_hi [NAXES];
	logic signed [WPROD_W-1:0] prod_lo [NAXES];
	logic signed [WPROD_W-1:0] prod_hi [NAXES];
	logic signed [WPROD_W:0]   diff [NAXES];
	logic signed [D_W-1:0]     d_nx [NAXES];
	logic signed [PLO_W-1:0]   plo_nx [NAXES];
	logic signed [PHI_W-1:0]   phi_nx [NAXES];
	logic signed [TERM_W-1:0]  term_nx [NAXES];
	logic signed [SUM_W-1:0]   sum_nx;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [WPROD_W-1:0] wl_s1 [NAXES];
	logic signed [WPROD_W-1:0] wh_s1 [NAXES];
	logic signed [D_W-1:0]     d_s2 [NAXES];
	logic signed [PLO_W-1:0]   plo_s3 [NAXES];
	logic signed [PHI_W-1:0]   phi_s3 [NAXES];
	logic signed [TERM_W-1:0]  term_s4 [NAXES];
	logic signed [SUM_W-1:0]   sum_s5;
	logic [VOL_W-1:0]          vol_s1, vol_s2, vol_s3, vol_s4, vol_s5;

	always_comb begin
		vol_raw = in_data[VOL_LSB +: VOL_W];
		for (int a = 0; a < NAXES; a++) begin
			f_lo[a] = $signed(in_data[(2*a)*FLUX_W +: FLUX_W]);
			f_hi[a] = $signed(in_data[(2*a+1)*FLUX_W +: FLUX_W]);
			pair[a] = in_data[AREA_LSB + a*PAIR_W +: PAIR_W];
		end
		// A regular cell is a cut cell whose fractions are all one; a covered
		// cell gets zero weights, so the sum and the rate come out as zero.
		case (in_class)
			CLS_CUT: begin
				for (int a = 0; a < NAXES; a++) begin
					wt_lo[a] = clamp_frac(pair[a][AREA_W-1:0]);
					wt_hi[a] = clamp_frac(pair[a][PAIR_W-1:AREA_W]);
				end
				vol_sel = clamp_frac(vol_raw);
				if (vol_sel == '0) begin
					vol_sel = VOL_W'(1);
				end
			end
			CLS_REGULAR: begin
				for (int a = 0; a < NAXES; a++) begin
					wt_lo[a] = ONE_Q15;
					wt_hi[a] = ONE_Q15;
				end
				vol_sel = ONE_Q15;
			end
			default: begin
				for (int a = 0; a < NAXES; a++) begin
					wt_lo[a] = '0;
					wt_hi[a] = '0;
				end
				vol_sel = ONE_Q15;
			end
		endcase
		for (int a = 0; a < NAXES; a++) begin
			prod_lo[a] = f_lo[a] * $signed({1'b0, wt_lo[a]});
			prod_hi[a] = f_hi[a] * $signed({1'b0, wt_hi[a]});
			diff[a]    = wl_s1[a] - wh_s1[a];
			// Arithmetic shift, so the fraction bits are dropped toward minus infinity.
			d_nx[a]    = $signed(diff[a][AFRAC_BITS +: D_W]);
			// The spacing is split in integer and fraction halves to keep
			// each multiplier narrow; the integer half needs no rounding.
			plo_nx[a]  = d_s2[a] * $signed({1'b0, inv[a][FRAC_BITS-1:0]});
			phi_nx[a]  = d_s2[a] * $signed({1'b0, inv[a][INV_W-1:FRAC_BITS]});
			term_nx[a] = phi_s3[a] + (plo_s3[a] >>> FRAC_BITS);
		end
		sum_nx = term_s4[0] + term_s4[1] + term_s4[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAXES; a++) begin
				wl_s1[a]   <= prod_lo[a];
				wh_s1[a]   <= prod_hi[a];
				d_s2[a]    <= d_nx[a];
				plo_s3[a]  <= plo_nx[a];
				phi_s3[a]  <= phi_nx[a];
				term_s4[a] <= term_nx[a];
			end
			sum_s5 <= sum_nx;
			vol_s1 <= vol_sel;
			vol_s2 <= vol_s1;
			vol_s3 <= vol_s2;
			vol_s4 <= vol_s3;
			vol_s5 <= vol_s4;
		end
	end

	assign out_valid   = v_s5;
	assign out_acc.sum = sum_s5;
	assign out_acc.vol = vol_s5;

endmodule

// ===== hdl/ccfd_div.sv =====
// Back pipeline: sign split, restoring division by the volume fraction,
// rounding toward minus infinity and saturation. Depends on ccfd_pkg.
module ccfd_div import ccfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  acc_t              in_acc,
	output logic              out_valid,
	output logic [RATE_W-1:0] out_rate,
	output logic              out_sat
);

	logic [SUM_W-1:0] sum_abs;
	logic [MAG_W-1:0] mag;
	logic [NUM_W-1:0] num;
	logic             big;

	logic [VOL_W:0]   t;
	logic [VOL_W-1:0] r;
	logic [Q_W-1:0]   l;
	logic [VOL_W-1:0] rem_nx [DIV_STAGES];
	logic [Q_W-1:0]   low_nx [DIV_STAGES];

	logic [Q_W-1:0]    quo;
	logic              rnd;
	logic [MAG_W-1:0]  quo_up;
	logic [RATE_W-1:0] rate_nx;
	logic              sat_nx;

	// Index 0 is the sign-split stage; index k+1 holds the remainder after
	// DIV_STEPS more quotient bits, which shift into the low dividend bits.
	logic             v_s   [DIV_STAGES+1];
	logic             neg_s [DIV_STAGES+1];
	logic             big_s [DIV_STAGES+1];
	logic [VOL_W-1:0] vol_s [DIV_STAGES+1];
	logic [VOL_W-1:0] rem_s [DIV_STAGES+1];
	logic [Q_W-1:0]   low_s [DIV_STAGES+1];

	logic              valid_q;
	logic [RATE_W-1:0] rate_q;
	logic              sat_q;

	always_comb begin
		sum_abs = in_acc.sum[SUM_W-1] ? $unsigned(-in_acc.sum) : $unsigned(in_acc.sum);
		mag     = (sum_abs > {{(SUM_W-MAG_W){1'b0}}, MAG_CLIP}) ? MAG_CLIP
			: sum_abs[MAG_W-1:0];
		num     = {mag, {AFRAC_BITS{1'b0}}};
		// A quotient of 2^32 or more saturates whatever its low bits are.
		big     = num[NUM_W-1:Q_W] >= in_acc.vol;
	end

	always_comb begin
		t = '0;
		r = '0;
		l = '0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			r = rem_s[k];
			l = low_s[k];
			for (int i = 0; i < DIV_STEPS; i++) begin
				t = {r, l[Q_W-1]};
				if (t >= {1'b0, vol_s[k]}) begin
					t = t - {1'b0, vol_s[k]};
					l = {l[Q_W-2:0], 1'b1};
				end else begin
					l = {l[Q_W-2:0], 1'b0};
				end
				r = t[VOL_W-1:0];
			end
			rem_nx[k] = r;
			low_nx[k] = l;
		end
	end

	always_comb begin
		quo    = low_s[DIV_STAGES];
		// Negative values round the magnitude up, giving the floor of the quotient.
		rnd    = neg_s[DIV_STAGES] && (rem_s[DIV_STAGES] != '0);
		quo_up = {1'b0, quo} + MAG_W'(rnd);
		if (big_s[DIV_STAGES]) begin
			sat_nx  = 1'b1;
			rate_nx = neg_s[DIV_STAGES] ? RATE_MIN : RATE_MAX;
		end else if (neg_s[DIV_STAGES]) begin
			if (quo_up > {1'b0, RATE_MIN}) begin
				sat_nx  = 1'b1;
				rate_nx = RATE_MIN;
			end else begin
				sat_nx  = 1'b0;
				rate_nx = RATE_W'(~quo_up + MAG_W'(1));
			end
		end else if (quo[Q_W-1]) begin
			sat_nx  = 1'b1;
			rate_nx = RATE_MAX;
		end else begin
			sat_nx  = 1'b0;
			rate_nx = quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				v_s[k] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < DIV_STAGES; k++) begin
				v_s[k+1] <= v_s[k];
			end
			valid_q <= v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= in_acc.sum[SUM_W-1];
			big_s[0] <= big;
			vol_s[0] <= in_acc.vol;
			rem_s[0] <= num[NUM_W-1:Q_W];
			low_s[0] <= num[Q_W-1:0];
			for (int k = 0; k < DIV_STAGES; k++) begin
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
				vol_s[k+1] <= vol_s[k];
				rem_s[k+1] <= rem_nx[k];
				low_s[k+1] <= low_nx[k];
			end
			rate_q <= rate_nx;
			sat_q  <= sat_nx;
		end
	end

	assign out_valid = valid_q;
	assign out_rate  = rate_q;
	assign out_sat   = sat_q;

endmodule

// ===== hdl/cut_cell_flux_divergence_unit.sv =====
// Top level of the cut-cell flux divergence unit: spacing registers, stream
// ports and the shared stall control. Depends on ccfd_pkg, ccfd_scale, ccfd_div.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   slave    | s_tvalid/s_tready  | s_tdata: six fluxes, three area pairs, vol
//            |                    | s_tuser: cell class
//   master   | m_tvalid/m_tready  | m_tdata: rate, m_tuser: saturated flag
//   config   | cfg_we             | cfg_index, cfg_data
//
// One item is taken every cycle while the output is not stalled; each passes through 23 register stages
// (five for weighting, scaling and summing, one sign split, sixteen divider
// stages of two quotient bits each, one output register).
// A single enable moves every stage: when m_tvalid is high and m_tready low,
// the whole pipeline holds and s_tready is low. Reset clears all valid bits and
// sets the three inverse spacings to one; no clearing pass is needed.
module cut_cell_flux_divergence_unit import ccfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// flux_x_low, flux_x_high, flux_y_low, flux_y_high, flux_z_low,
	// flux_z_high, area_x_pair, area_y_pair, area_z_pair, vol_frac
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cell_class
	input  logic [CLASS_W-1:0]   s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// rate
	output logic [RATE_W-1:0]    m_tdata,
	// saturated
	output logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [INV_W-1:0]     cfg_data
);

	inv_set_t inv_q;
	logic     en;
	logic     acc_valid;
	acc_t     acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= {NAXES{INV_RESET}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_X: inv_q[0] <= cfg_data;
				REG_INV_Y: inv_q[1] <= cfg_data;
				REG_INV_Z: inv_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	ccfd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.in_class  (s_tuser),
		.inv       (inv_q),
		.out_valid (acc_valid),
		.out_acc   (acc)
	);

	ccfd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (acc_valid),
		.in_acc    (acc),
		.out_valid (m_tvalid),
		.out_rate  (m_tdata),
		.out_sat   (m_tuser)
	);

endmodule

// ===== hdl/ccfd_checker.sv =====
// Port-level checker for the cut-cell flux divergence unit, bound to the top.
// Depends on ccfd_pkg and cut_cell_flux_divergence_unit_assert.svh.
module ccfd_checker import ccfd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [RATE_W-1:0] m_tdata,
	input logic              m_tuser
);

`include "cut_cell_flux_divergence_unit_assert.svh"

	`CCFD_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

	// The pipeline moves as one, so input readiness follows the output side.
	`CCFD_ASSERT(a_in_ready, clk, arst_n, s_tready == (!m_tvalid || m_tready), "input ready does not follow the output stall")

	`CCFD_ASSERT(a_sat_rail, clk, arst_n, m_tvalid && m_tuser |-> (m_tdata == RATE_MAX || m_tdata == RATE_MIN), "saturated rate is not at a rail")

	// The valid bits are cleared asynchronously as soon as reset is asserted.
	`CCFD_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_tvalid, "result item shown during reset")

endmodule

bind cut_cell_flux_divergence_unit ccfd_checker u_ccfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
